[rtl/core/scfb_pkg.sv]
// ============================================================================
// scfb_pkg
// Shared types and constants of the single-color fade and blink effect block.
// ============================================================================
package scfb_pkg;

   // Stream payload widths.
   localparam int ReqDataW = 32;
   localparam int RspDataW = 24;
   localparam int ColorW   = 8;
   localparam int Lanes    = 3;

   // Register file: three registers at byte addresses 0, 4 and 8.
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 32;
   localparam int RegIdxW  = 2;

   localparam logic [RegIdxW-1:0] RegFadeSpeed  = 2'd0;
   localparam logic [RegIdxW-1:0] RegBlinkSpeed = 2'd1;
   localparam logic [RegIdxW-1:0] RegBrightness = 2'd2;

   localparam logic [7:0] FadeSpeedReset  = 8'd100;
   localparam logic [7:0] BlinkSpeedReset = 8'd3;
   localparam logic [6:0] BrightnessReset = 7'd50;

   // Routine codes carried in the request.
   localparam logic [2:0] RoutineSolid  = 3'd0;
   localparam logic [2:0] RoutineBlink  = 3'd1;
   localparam logic [2:0] RoutineLinear = 3'd2;
   localparam logic [2:0] RoutineSawIn  = 3'd3;
   localparam logic [2:0] RoutineSawOut = 3'd4;

   localparam logic [7:0] LinearStep  = 8'd2;
   localparam logic [7:0] PercentFull = 8'd100;

   // Restoring divider: one quotient bit per cycle over a 16-bit dividend.
   localparam int NumW  = 16;
   localparam int StepW = 4;
   localparam logic [StepW-1:0] LastStep = 4'd15;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FADE_MUL,
      ST_FADE_DIV,
      ST_SCALE_MUL,
      ST_SCALE_DIV,
      ST_DONE
   } state_type;

endpackage

[rtl/core/single_color_fade_blink_effect.sv]
// ============================================================================
// single_color_fade_blink_effect
// Frame color generator: solid, blink, triangle and sawtooth fades, then a
// percent brightness scaling, with the divisions done one bit per cycle.
// ============================================================================
// Fade routines run FADE_MUL, a bit-serial FADE_DIV, SCALE_MUL, a bit-serial
// SCALE_DIV and DONE; solid and blink go straight to SCALE_MUL. A new request
// is taken only in IDLE, once the last one has left DONE; the restoring divider
// lanes are shared by both divisions, and req_tready returns as soon as the
// result is registered, even while rsp is stalled.
// Reset is synchronous and active high; it restores the register defaults and
// the effect state (solid routine, counter zero, rising direction).
module single_color_fade_blink_effect (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] routine, [10:3] base_red, [18:11] base_green, [26:19] base_blue
   input  logic [31:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_red, [15:8] out_green, [23:16] out_blue
   output logic [23:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration registers.
   logic [7:0] fade_speed_ff, blink_speed_ff;
   logic [6:0] brightness_ff;
   logic [scfb_pkg::RegIdxW-1:0] csr_idx;
   logic csr_wr;

   // Effect state.
   logic [2:0] active_ff, active_in;
   logic [7:0] ramp_ff, ramp_in;
   logic       rising_ff, rising_in;
   logic [7:0] phase_ff, phase_in;
   logic [7:0] held_ff [scfb_pkg::Lanes];
   logic [7:0] held_in [scfb_pkg::Lanes];

   // Sequencer and divider lanes.
   scfb_pkg::state_type state_ff, state_in;
   logic [scfb_pkg::StepW-1:0] step_ff, step_in;
   logic [7:0] cnt_ff, cnt_in;
   logic [7:0] col_ff [scfb_pkg::Lanes];
   logic [7:0] col_in [scfb_pkg::Lanes];
   logic [7:0] rem_ff [scfb_pkg::Lanes];
   logic [7:0] rem_in [scfb_pkg::Lanes];
   logic [scfb_pkg::NumW-1:0] num_ff [scfb_pkg::Lanes];
   logic [scfb_pkg::NumW-1:0] num_in [scfb_pkg::Lanes];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [23:0] rsp_data_ff, rsp_data_in;

   // Combinational helpers.
   logic       accept;
   logic [2:0] rt;
   logic [7:0] base [scfb_pkg::Lanes];
   logic       chg;
   logic [7:0] r0, p0;
   logic       f0;
   logic [7:0] h0 [scfb_pkg::Lanes];
   logic [7:0] fs_eff, bs_eff, divisor;
   logic [8:0] lin_up, p_inc;
   logic [7:0] lin_dn, r1;
   logic [8:0] trial [scfb_pkg::Lanes];
   logic       fits [scfb_pkg::Lanes];
   logic [7:0] sat [scfb_pkg::Lanes];

   function automatic logic [7:0] sat8(input logic [scfb_pkg::NumW-1:0] v);
      sat8 = (|v[scfb_pkg::NumW-1:8]) ? 8'hFF : v[7:0];
   endfunction

   // Register port.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_idx)
         scfb_pkg::RegFadeSpeed:  csr_prdata = {24'd0, fade_speed_ff};
         scfb_pkg::RegBlinkSpeed: csr_prdata = {24'd0, blink_speed_ff};
         scfb_pkg::RegBrightness: csr_prdata = {25'd0, brightness_ff};
         default:                 csr_prdata = '0;
      endcase
   end

   assign req_tready = (state_ff == scfb_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign rt      = req_tdata[2:0];
   assign base[0] = req_tdata[10:3];
   assign base[1] = req_tdata[18:11];
   assign base[2] = req_tdata[26:19];

   // A routine change restarts the ramp before the frame is drawn.
   assign chg    = (rt != active_ff);
   assign r0     = chg ? ((rt == scfb_pkg::RoutineSawOut) ? fade_speed_ff : 8'd0) : ramp_ff;
   assign f0     = chg ? 1'b1 : rising_ff;
   assign p0     = chg ? 8'd0 : phase_ff;
   assign fs_eff = (fade_speed_ff == 8'd0) ? 8'd1 : fade_speed_ff;
   assign bs_eff = (blink_speed_ff == 8'd0) ? 8'd1 : blink_speed_ff;
   assign lin_up = {1'b0, r0} + {1'b0, scfb_pkg::LinearStep};
   assign lin_dn = (r0 < scfb_pkg::LinearStep) ? 8'd0 : r0 - scfb_pkg::LinearStep;
   assign p_inc  = {1'b0, p0} + 9'd1;
   assign divisor = (state_ff == scfb_pkg::ST_FADE_DIV) ? fs_eff : scfb_pkg::PercentFull;

   // One restoring-division step per lane.
   always_comb begin
      for (int i = 0; i < scfb_pkg::Lanes; i++) begin
         h0[i]    = chg ? 8'd0 : held_ff[i];
         trial[i] = {rem_ff[i], num_ff[i][scfb_pkg::NumW-1]};
         fits[i]  = (trial[i] >= {1'b0, divisor});
         sat[i]   = sat8(num_ff[i]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      active_in    = active_ff;
      ramp_in      = ramp_ff;
      rising_in    = rising_ff;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      r1           = 8'd0;
      for (int i = 0; i < scfb_pkg::Lanes; i++) begin
         held_in[i] = held_ff[i];
         col_in[i]  = col_ff[i];
         rem_in[i]  = rem_ff[i];
         num_in[i]  = num_ff[i];
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         scfb_pkg::ST_IDLE: begin
            if (accept) begin
               active_in = rt;
               ramp_in   = r0;
               rising_in = f0;
               phase_in  = p0;
               for (int i = 0; i < scfb_pkg::Lanes; i++) begin
                  held_in[i] = h0[i];
                  col_in[i]  = base[i];
               end
               state_in = scfb_pkg::ST_FADE_MUL;
               case (rt)
                  scfb_pkg::RoutineBlink: begin
                     if (p0 == 8'd0) begin
                        for (int i = 0; i < scfb_pkg::Lanes; i++) begin
                           held_in[i] = f0 ? base[i] : 8'd0;
                        end
                        rising_in = ~f0;
                     end
                     phase_in = (p_inc >= {1'b0, bs_eff}) ? 8'd0 : p_inc[7:0];
                     for (int i = 0; i < scfb_pkg::Lanes; i++) begin
                        col_in[i] = (p0 == 8'd0) ? (f0 ? base[i] : 8'd0) : h0[i];
                     end
                     state_in = scfb_pkg::ST_SCALE_MUL;
                  end
                  scfb_pkg::RoutineLinear: begin
                     // The frame uses the counter from before the step.
                     r1 = f0 ? (lin_up[8] ? 8'hFF : lin_up[7:0]) : lin_dn;
                     ramp_in = r1;
                     cnt_in  = r0;
                     if (r1 >= fs_eff) begin
                        rising_in = 1'b0;
                     end else if (r1 == 8'd0) begin
                        rising_in = 1'b1;
                     end
                  end
                  scfb_pkg::RoutineSawIn: begin
                     r1 = f0 ? ((r0 == 8'hFF) ? 8'hFF : r0 + 8'd1) : 8'd0;
                     ramp_in   = r1;
                     cnt_in    = r1;
                     rising_in = (r1 < fs_eff);
                  end
                  scfb_pkg::RoutineSawOut: begin
                     r1 = f0 ? ((r0 == 8'd0) ? 8'd0 : r0 - 8'd1) : fade_speed_ff;
                     ramp_in   = r1;
                     cnt_in    = r1;
                     rising_in = (r1 != 8'd0);
                  end
                  default: begin
                     state_in = scfb_pkg::ST_SCALE_MUL;
                  end
               endcase
            end
         end
         scfb_pkg::ST_FADE_MUL: begin
            for (int i = 0; i < scfb_pkg::Lanes; i++) begin
               num_in[i] = 16'(col_ff[i]) * 16'(cnt_ff);
               rem_in[i] = 8'd0;
            end
            step_in  = '0;
            state_in = scfb_pkg::ST_FADE_DIV;
         end
         scfb_pkg::ST_FADE_DIV, scfb_pkg::ST_SCALE_DIV: begin
            for (int i = 0; i < scfb_pkg::Lanes; i++) begin
               rem_in[i] = fits[i] ? 8'(trial[i] - {1'b0, divisor}) : trial[i][7:0];
               num_in[i] = {num_ff[i][scfb_pkg::NumW-2:0], fits[i]};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == scfb_pkg::LastStep) begin
               state_in = (state_ff == scfb_pkg::ST_FADE_DIV) ?
                          scfb_pkg::ST_SCALE_MUL : scfb_pkg::ST_DONE;
            end
         end
         scfb_pkg::ST_SCALE_MUL: begin
            // After a fade division the quotient is still in the lanes.
            for (int i = 0; i < scfb_pkg::Lanes; i++) begin
               num_in[i] = 16'({col_ff[i], 1'b0} >> 1) * 16'(brightness_ff);
               rem_in[i] = 8'd0;
            end
            step_in  = '0;
            state_in = scfb_pkg::ST_SCALE_DIV;
         end
         scfb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sat[2], sat[1], sat[0]};
               state_in     = scfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scfb_pkg::ST_IDLE;
         end
      endcase

      // The fade quotient replaces the lane color before brightness scaling.
      if (state_ff == scfb_pkg::ST_FADE_DIV && step_ff == scfb_pkg::LastStep) begin
         for (int i = 0; i < scfb_pkg::Lanes; i++) begin
            col_in[i] = sat8({num_ff[i][scfb_pkg::NumW-2:0], fits[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_speed_ff  <= scfb_pkg::FadeSpeedReset;
         blink_speed_ff <= scfb_pkg::BlinkSpeedReset;
         brightness_ff  <= scfb_pkg::BrightnessReset;
         state_ff       <= scfb_pkg::ST_IDLE;
         step_ff        <= '0;
         active_ff      <= scfb_pkg::RoutineSolid;
         ramp_ff        <= 8'd0;
         rising_ff      <= 1'b1;
         phase_ff       <= 8'd0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < scfb_pkg::Lanes; i++) begin
            held_ff[i] <= 8'd0;
         end
      end else begin
         if (csr_wr) begin
            case (csr_idx)
               scfb_pkg::RegFadeSpeed:  fade_speed_ff  <= csr_pwdata[7:0];
               scfb_pkg::RegBlinkSpeed: blink_speed_ff <= csr_pwdata[7:0];
               scfb_pkg::RegBrightness: brightness_ff  <= csr_pwdata[6:0];
               default: ;
            endcase
         end
         state_ff     <= state_in;
         step_ff      <= step_in;
         active_ff    <= active_in;
         ramp_ff      <= ramp_in;
         rising_ff    <= rising_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < scfb_pkg::Lanes; i++) begin
            held_ff[i] <= held_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < scfb_pkg::Lanes; i++) begin
         col_ff[i] <= col_in[i];
         rem_ff[i] <= rem_in[i];
         num_ff[i] <= num_in[i];
      end
   end

endmodule

[rtl/core/scfb_checker.sv]
// ============================================================================
// scfb_checker
// Port-level checks of the fade and blink effect block, bound to the top level.
// ============================================================================
module scfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        csr_pready
);

   // A stalled result keeps its transaction until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed or dropped");

   // The block drops req_tready once it takes a request.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a frame is in progress");

   // A result never follows its request in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("response appeared too early");

   // No result is pending right after reset, and the register port never waits.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid && csr_pready)
      else $error("response pending after reset or register port stalled");

endmodule

bind single_color_fade_blink_effect scfb_checker u_scfb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
